[rtl/core/sdmbr_pkg.sv]
`timescale 1ns / 1ps
// sdmbr_pkg: shared types, constants and CRC step functions for the
// SD SPI multiple-block reader. No dependencies.
package sdmbr_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int BC_W        = 10;   // byte counter width, counts 0 to 1023
	localparam int PADDR_W     = 4;

	// register index (paddr[3:2])
	localparam logic [1:0] REG_DATA_TOKEN  = 2'd0;
	localparam logic [1:0] REG_POLL_LIMIT  = 2'd1;
	localparam logic [1:0] REG_FLUSH_COUNT = 2'd2;

	localparam logic [7:0] DATA_TOKEN_RST  = 8'hFE;
	localparam logic [7:0] POLL_LIMIT_RST  = 8'd100;
	localparam logic [3:0] FLUSH_COUNT_RST = 4'd8;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_CRC    = 2'd2;

	// request types
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_RX    = 1'b1;

	// frame bytes
	localparam logic [7:0] BYTE_IDLE   = 8'hFF;
	localparam logic [7:0] CMD18_BYTE  = 8'h52;
	localparam logic [7:0] CMD12_BYTE  = 8'h4C;
	localparam logic [7:0] CMD12_CRC   = 8'h01;

	typedef struct packed {
		logic [7:0] data_token;
		logic [7:0] poll_limit;
		logic [3:0] flush_count;
	} cfg_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       done_res;
		logic [1:0] status;
	} res_t;

	// CRC7, poly x^7+x^3+1, MSB first, one byte
	function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
		logic [6:0] crc;
		logic [7:0] bb;
		logic       fb;
		crc = crc_in;
		bb  = b;
		for (int i = 0; i < 8; i++) begin
			fb  = crc[6] ^ bb[7];
			crc = {crc[5:0], 1'b0};
			if (fb) begin
				crc = crc ^ 7'h09;
			end
			bb  = {bb[6:0], 1'b0};
		end
		return crc;
	endfunction

	// CRC-16/XMODEM, poly 0x1021, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] crc;
		crc = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (crc[15]) begin
				crc = {crc[14:0], 1'b0} ^ 16'h1021;
			end else begin
				crc = {crc[14:0], 1'b0};
			end
		end
		return crc;
	endfunction

endpackage

[rtl/core/sd_spi_multiblock_reader_top.sv]
`timescale 1ns / 1ps
// sd_spi_multiblock_reader_top: top level of the SD SPI multiple-block reader.
// Depends on sdmbr_pkg, sdmbr_regs, sdmbr_engine, sdmbr_outbuf.

// Host-side SD SPI read engine. A start beat (req_type 0) latches the LBA and
// block count and answers with an idle 0xFF byte ahead of the READ_MULTIPLE_BLOCK frame;
// every later beat (req_type 1) carries the byte clocked in for the previously
// transmitted byte and returns exactly one result beat: the next byte to send,
// an optional payload byte, and done/status at the end of the operation. A
// start while busy abandons the running read. Throughput is one beat per clock
// in both directions while no stall holds it; a result appears in the cycle after
// its request is accepted, held in a single result register. The request side
// stalls only while that register is full and the consumer stalls it. The per-byte
// CRC7/CRC16 and sequencing update is the only logic in the path, so nothing else
// limits rate. There is no clearing pass after reset. Registers (APB, byte addresses):
// 0x0 data token (reset 0xFE), 0x4 poll limit (reset 100), 0x8 flush count
// (reset 8). Write them only while no read is in flight.
module sd_spi_multiblock_reader_top
	import sdmbr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               req_type,
	input  logic [31:0]        start_lba,
	input  logic [31:0]        block_count,
	input  logic [7:0]         rx_byte,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output logic               tx_valid,
	output logic [7:0]         tx_byte,
	output logic               data_valid,
	output logic [7:0]         data_byte,
	output logic               done_res,
	output logic [1:0]         status,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t cfg;
	res_t res_next;
	res_t res_out;
	logic buf_full;
	logic accept;

	// result register either empty or draining this cycle frees the slot
	assign req_stall = buf_full & res_stall;
	assign accept    = req_valid & ~req_stall;

	sdmbr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sdmbr_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.req_type    (req_type),
		.start_lba   (start_lba),
		.block_count (block_count),
		.rx_byte     (rx_byte),
		.cfg         (cfg),
		.res         (res_next)
	);

	sdmbr_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_in    (res_next),
		.full      (buf_full),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_out   (res_out)
	);

	assign tx_valid   = res_out.tx_valid;
	assign tx_byte    = res_out.tx_byte;
	assign data_valid = res_out.data_valid;
	assign data_byte  = res_out.data_byte;
	assign done_res   = res_out.done_res;
	assign status     = res_out.status;

endmodule

[rtl/core/sdmbr_regs.sv]
`timescale 1ns / 1ps
// sdmbr_regs: APB configuration registers (data token, poll limit, flush count).
// Depends on sdmbr_pkg.
module sdmbr_regs
	import sdmbr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_token  <= DATA_TOKEN_RST;
			cfg_q.poll_limit  <= POLL_LIMIT_RST;
			cfg_q.flush_count <= FLUSH_COUNT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DATA_TOKEN:  cfg_q.data_token  <= pwdata[7:0];
				REG_POLL_LIMIT:  cfg_q.poll_limit  <= pwdata[7:0];
				REG_FLUSH_COUNT: cfg_q.flush_count <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DATA_TOKEN:  prdata = {24'h0, cfg_q.data_token};
			REG_POLL_LIMIT:  prdata = {24'h0, cfg_q.poll_limit};
			REG_FLUSH_COUNT: prdata = {28'h0, cfg_q.flush_count};
			default:         prdata = 32'h0;
		endcase
	end

endmodule

[rtl/core/sdmbr_engine.sv]
`timescale 1ns / 1ps
// sdmbr_engine: read sequencer state and the per-beat next-state / result logic.
// Depends on sdmbr_pkg.
module sdmbr_engine
	import sdmbr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        req_type,
	input  logic [31:0] start_lba,
	input  logic [31:0] block_count,
	input  logic [7:0]  rx_byte,
	input  cfg_t        cfg,
	output res_t        res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_RCMD, PH_RPOLL, PH_FLUSH, PH_HUNT, PH_DATA,
		PH_CRCHI, PH_CRCLO, PH_SCMD, PH_SPOLL, PH_SDUMMY
	} phase_t;

	phase_t          phase_q, phase_n;
	logic [BC_W-1:0] bcnt_q, bcnt_n, bcnt_inc;
	logic [7:0]      poll_q, poll_n, poll_inc;
	logic [15:0]     crc16_q, crc16_n;
	logic [7:0]      crc_hi_q, crc_hi_n;
	logic [6:0]      crc7_q, crc7_n;
	logic [31:0]     addr_q, addr_n;
	logic [31:0]     left_q, left_n, left_dec;
	logic [1:0]      rcode_q, rcode_n;
	logic            poll_done;
	logic [7:0]      frame_b;
	logic            is_stop;

	assign bcnt_inc = bcnt_q + BC_W'(1);
	assign poll_inc = poll_q + 8'd1;
	assign left_dec = left_q - 32'd1;
	assign is_stop  = (phase_q == PH_SCMD);

	// response poll ends on bit 7 clear or when the limit is hit
	assign poll_done = ~rx_byte[7] | (poll_inc >= cfg.poll_limit) | (poll_inc == 8'd0);

	// next command frame byte, indexed by bcnt_inc
	always_comb begin
		case (bcnt_inc)
			BC_W'(1): frame_b = is_stop ? CMD12_BYTE : CMD18_BYTE;
			BC_W'(2): frame_b = is_stop ? 8'h00 : addr_q[31:24];
			BC_W'(3): frame_b = is_stop ? 8'h00 : addr_q[23:16];
			BC_W'(4): frame_b = is_stop ? 8'h00 : addr_q[15:8];
			BC_W'(5): frame_b = is_stop ? 8'h00 : addr_q[7:0];
			default:  frame_b = is_stop ? CMD12_CRC : {crc7_q, 1'b1};
		endcase
	end

	always_comb begin
		phase_n  = phase_q;
		bcnt_n   = bcnt_q;
		poll_n   = poll_q;
		crc16_n  = crc16_q;
		crc_hi_n = crc_hi_q;
		crc7_n   = crc7_q;
		addr_n   = addr_q;
		left_n   = left_q;
		rcode_n  = rcode_q;
		res      = '0;

		if (req_type == REQ_START) begin
			addr_n   = start_lba;
			left_n   = (block_count == 32'd0) ? 32'd1 : block_count;
			crc7_n   = 7'd0;
			rcode_n  = ST_OK;
			crc16_n  = 16'd0;
			crc_hi_n = 8'd0;
			poll_n   = 8'd0;
			bcnt_n   = '0;
			phase_n  = PH_RCMD;
			res.tx_valid = 1'b1;
			res.tx_byte  = BYTE_IDLE;
		end else begin
			case (phase_q)
				PH_RCMD, PH_SCMD: begin
					res.tx_valid = 1'b1;
					if (bcnt_q >= BC_W'(6)) begin
						poll_n      = 8'd0;
						phase_n     = is_stop ? PH_SPOLL : PH_RPOLL;
						res.tx_byte = BYTE_IDLE;
					end else begin
						bcnt_n      = bcnt_inc;
						res.tx_byte = frame_b;
						// fold command and address bytes into CRC7 as they go out
						if (!is_stop && bcnt_inc <= BC_W'(5)) begin
							crc7_n = crc7_byte(crc7_q, frame_b);
						end
					end
				end
				PH_RPOLL: begin
					if (!poll_done) begin
						poll_n       = poll_inc;
						res.tx_valid = 1'b1;
						res.tx_byte  = BYTE_IDLE;
					end else if (rx_byte == 8'h00) begin
						phase_n      = PH_HUNT;
						res.tx_valid = 1'b1;
						res.tx_byte  = BYTE_IDLE;
					end else begin
						rcode_n = ST_REJECT;
						bcnt_n  = '0;
						if (cfg.flush_count == 4'd0) begin
							phase_n      = PH_IDLE;
							res.done_res = 1'b1;
							res.status   = ST_REJECT;
						end else begin
							phase_n      = PH_FLUSH;
							res.tx_valid = 1'b1;
							res.tx_byte  = BYTE_IDLE;
						end
					end
				end
				PH_FLUSH: begin
					bcnt_n = bcnt_inc;
					if (bcnt_inc >= BC_W'(cfg.flush_count)) begin
						phase_n      = PH_IDLE;
						res.done_res = 1'b1;
						res.status   = rcode_q;
					end else begin
						res.tx_valid = 1'b1;
						res.tx_byte  = BYTE_IDLE;
					end
				end
				PH_HUNT: begin
					if (rx_byte == cfg.data_token) begin
						phase_n = PH_DATA;
						bcnt_n  = '0;
						crc16_n = 16'd0;
					end
					res.tx_valid = 1'b1;
					res.tx_byte  = BYTE_IDLE;
				end
				PH_DATA: begin
					crc16_n = crc16_byte(crc16_q, rx_byte);
					if (bcnt_q >= BC_W'(BLOCK_BYTES - 1)) begin
						phase_n = PH_CRCHI;
						bcnt_n  = '0;
					end else begin
						bcnt_n = bcnt_inc;
					end
					res.tx_valid   = 1'b1;
					res.tx_byte    = BYTE_IDLE;
					res.data_valid = 1'b1;
					res.data_byte  = rx_byte;
				end
				PH_CRCHI: begin
					crc_hi_n     = rx_byte;
					phase_n      = PH_CRCLO;
					res.tx_valid = 1'b1;
					res.tx_byte  = BYTE_IDLE;
				end
				PH_CRCLO: begin
					left_n = left_dec;
					if ({crc_hi_q, rx_byte} != crc16_q) begin
						rcode_n = ST_CRC;
						bcnt_n  = '0;
						phase_n = PH_SCMD;
					end else if (left_dec != 32'd0) begin
						phase_n = PH_HUNT;
					end else begin
						bcnt_n  = '0;
						phase_n = PH_SCMD;
					end
					res.tx_valid = 1'b1;
					res.tx_byte  = BYTE_IDLE;
				end
				PH_SPOLL: begin
					if (poll_done) begin
						phase_n = PH_SDUMMY;
					end else begin
						poll_n = poll_inc;
					end
					res.tx_valid = 1'b1;
					res.tx_byte  = BYTE_IDLE;
				end
				PH_SDUMMY: begin
					phase_n      = PH_IDLE;
					res.done_res = 1'b1;
					res.status   = rcode_q;
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bcnt_q   <= '0;
			poll_q   <= 8'd0;
			crc16_q  <= 16'd0;
			crc_hi_q <= 8'd0;
			crc7_q   <= 7'd0;
			addr_q   <= 32'd0;
			left_q   <= 32'd0;
			rcode_q  <= ST_OK;
		end else if (accept) begin
			phase_q  <= phase_n;
			bcnt_q   <= bcnt_n;
			poll_q   <= poll_n;
			crc16_q  <= crc16_n;
			crc_hi_q <= crc_hi_n;
			crc7_q   <= crc7_n;
			addr_q   <= addr_n;
			left_q   <= left_n;
			rcode_q  <= rcode_n;
		end
	end

endmodule

[rtl/core/sdmbr_outbuf.sv]
`timescale 1ns / 1ps
// sdmbr_outbuf: result register with valid/stall handshake toward the consumer.
// Depends on sdmbr_pkg.
module sdmbr_outbuf
	import sdmbr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	output logic full,
	input  logic res_stall,
	output logic res_valid,
	output res_t res_out
);

	logic valid_q;
	res_t res_q;

	assign full      = valid_q;
	assign res_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

[tb/sd_spi_multiblock_reader_top_test.sv]
`timescale 1ns / 1ps
// sd_spi_multiblock_reader_top_test: self-checking bench for the SD SPI multiple-block reader.
// Needs sdmbr_pkg and the RTL below sd_spi_multiblock_reader_top; predicts every result beat.
module sd_spi_multiblock_reader_top_test;
	import sdmbr_pkg::*;

	// no accepted beat on either side for this many cycles ends the run
	localparam int STALL_LIMIT = 2000;

	// one request beat as it goes onto the request channel
	typedef struct packed {
		bit        kind;
		bit [31:0] lba;
		bit [31:0] count;
		bit [7:0]  rx;
	} beat_t;

	// engine sequencing, one state per stretch of the SPI transaction
	typedef enum bit [3:0] {
		S_IDLE, S_CMD, S_RESP, S_FLUSH, S_HUNT, S_DATA,
		S_CRC_HI, S_CRC_LO, S_STOP, S_STOP_RESP, S_STOP_PAD
	} eng_state_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic              req_type = REQ_RX;
	logic [31:0]       start_lba = '0;
	logic [31:0]       block_count = '0;
	logic [7:0]        rx_byte = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic              tx_valid;
	logic [7:0]        tx_byte;
	logic              data_valid;
	logic [7:0]        data_byte;
	logic              done_res;
	logic [1:0]        status;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	sd_spi_multiblock_reader_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.start_lba  (start_lba),
		.block_count(block_count),
		.rx_byte    (rx_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.data_valid (data_valid),
		.data_byte  (data_byte),
		.done_res   (done_res),
		.status     (status),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #6 clk = ~clk;

	// beats waiting to be driven, and result beats the engine still owes us
	beat_t spi_beats[$];
	res_t  results_due[$];
	int    mismatches = 0;

	// our copy of the register file
	bit [7:0] tok_cfg   = DATA_TOKEN_RST;
	bit [7:0] plim_cfg  = POLL_LIMIT_RST;
	bit [3:0] flush_cfg = FLUSH_COUNT_RST;

	// our copy of the engine state
	eng_state_t eng_state  = S_IDLE;
	bit [9:0]   byte_cnt   = '0;
	bit [7:0]   poll_cnt   = '0;
	bit [15:0]  crc_run    = '0;
	bit [15:0]  crc_got    = '0;
	bit [6:0]   crc_cmd    = '0;
	bit [31:0]  lba_cur    = '0;
	bit [31:0]  blocks_rem = '0;
	bit [1:0]   end_code   = ST_OK;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// CRC7 x^7+x^3+1, bit-serial, MSB first
	function automatic bit [6:0] crc7_next(input bit [6:0] c, input bit [7:0] b);
		bit fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[6] ^ b[i];
			c  = c << 1;
			if (fb) begin
				c ^= 7'h09;
			end
		end
		return c;
	endfunction

	// CRC-16/XMODEM, bit-serial, MSB first
	function automatic bit [15:0] crc16_next(input bit [15:0] c, input bit [7:0] b);
		bit fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c  = c << 1;
			if (fb) begin
				c ^= 16'h1021;
			end
		end
		return c;
	endfunction

	// byte idx of the read (CMD18) or stop (CMD12) frame
	function automatic bit [7:0] frame_out(input int idx, input bit stop);
		bit [31:0] arg;
		arg = stop ? 32'd0 : lba_cur;
		case (idx)
			0: return BYTE_IDLE;
			1: return stop ? CMD12_BYTE : CMD18_BYTE;
			2, 3, 4, 5: return arg[8*(5-idx) +: 8];
			default: return stop ? CMD12_CRC : {crc_cmd, 1'b1};
		endcase
	endfunction

	// a response byte has bit 7 clear; a limit of zero acts as one
	function automatic bit poll_done(input bit [7:0] rx);
		bit [7:0] cnt1;
		if (!rx[7]) begin
			return 1'b1;
		end
		cnt1 = poll_cnt + 8'd1;
		if (cnt1 >= plim_cfg || cnt1 == 8'd0) begin
			return 1'b1;
		end
		poll_cnt = cnt1;
		return 1'b0;
	endfunction

	function automatic res_t done_beat(input bit [1:0] code);
		res_t r;
		r = '0;
		r.done_res = 1'b1;
		r.status   = code;
		return r;
	endfunction

	// advance the engine by one accepted beat, return the result it owes
	function automatic res_t spi_read_step(input beat_t b);
		res_t r;
		bit   stop;
		r = '0;
		r.tx_valid = 1'b1;
		r.tx_byte  = BYTE_IDLE;
		// a start always wins, even over a read in flight
		if (b.kind == REQ_START) begin
			lba_cur    = b.lba;
			blocks_rem = (b.count == 32'd0) ? 32'd1 : b.count;
			crc_cmd    = crc7_next(7'd0, CMD18_BYTE);
			for (int i = 3; i >= 0; i--)
				crc_cmd = crc7_next(crc_cmd, lba_cur[8*i +: 8]);
			end_code  = ST_OK;
			crc_run   = '0;
			crc_got   = '0;
			poll_cnt  = '0;
			byte_cnt  = '0;
			eng_state = S_CMD;
			return r;
		end
		case (eng_state)
			S_CMD, S_STOP: begin
				stop = (eng_state == S_STOP);
				if (byte_cnt >= 10'd6) begin
					poll_cnt  = '0;
					eng_state = stop ? S_STOP_RESP : S_RESP;
				end else begin
					byte_cnt  = byte_cnt + 10'd1;
					r.tx_byte = frame_out(int'(byte_cnt), stop);
				end
			end
			S_RESP: begin
				if (poll_done(b.rx)) begin
					if (b.rx == 8'h00) begin
						eng_state = S_HUNT;
					end else begin
						// reject or no response: flush, or finish on this byte
						end_code = ST_REJECT;
						byte_cnt = '0;
						if (flush_cfg == 4'd0) begin
							eng_state = S_IDLE;
							r = done_beat(ST_REJECT);
						end else begin
							eng_state = S_FLUSH;
						end
					end
				end
			end
			S_FLUSH: begin
				byte_cnt = byte_cnt + 10'd1;
				if (byte_cnt >= 10'(flush_cfg)) begin
					eng_state = S_IDLE;
					r = done_beat(end_code);
				end
			end
			S_HUNT: begin
				if (b.rx == tok_cfg) begin
					eng_state = S_DATA;
					byte_cnt  = '0;
					crc_run   = '0;
				end
			end
			S_DATA: begin
				crc_run = crc16_next(crc_run, b.rx);
				if (byte_cnt >= 10'(BLOCK_BYTES - 1)) begin
					eng_state = S_CRC_HI;
					byte_cnt  = '0;
				end else begin
					byte_cnt = byte_cnt + 10'd1;
				end
				r.data_valid = 1'b1;
				r.data_byte  = b.rx;
			end
			S_CRC_HI: begin
				crc_got   = {b.rx, 8'h00};
				eng_state = S_CRC_LO;
			end
			S_CRC_LO: begin
				crc_got[7:0] = b.rx;
				blocks_rem   = blocks_rem - 32'd1;
				// a bad block skips the rest, but the stop command still goes out
				if (crc_got != crc_run) begin
					end_code  = ST_CRC;
					byte_cnt  = '0;
					eng_state = S_STOP;
				end else if (blocks_rem != 32'd0) begin
					eng_state = S_HUNT;
				end else begin
					byte_cnt  = '0;
					eng_state = S_STOP;
				end
			end
			S_STOP_RESP: begin
				// response value after stop is don't-care
				if (poll_done(b.rx)) begin
					eng_state = S_STOP_PAD;
				end
			end
			S_STOP_PAD: begin
				eng_state = S_IDLE;
				r = done_beat(end_code);
			end
			default: begin
				// received byte while idle: dropped, all-zero result
				eng_state = S_IDLE;
				r = '0;
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders (all zero-time, used only while the queue is empty
	// or being filled for the next phase)
	// ------------------------------------------------------------------

	function automatic void push_beat(input bit kind, input bit [31:0] lba,
			input bit [31:0] count, input bit [7:0] rx);
		beat_t b;
		b.kind  = kind;
		b.lba   = lba;
		b.count = count;
		b.rx    = rx;
		spi_beats.push_back(b);
	endfunction

	// unused fields of a beat carry noise
	function automatic void push_start(input bit [31:0] lba, input bit [31:0] count);
		push_beat(REQ_START, lba, count, 8'($urandom));
	endfunction

	function automatic void push_rx(input bit [7:0] rx);
		push_beat(REQ_RX, $urandom, $urandom, rx);
	endfunction

	function automatic int eff_limit();
		return (plim_cfg == 8'd0) ? 1 : int'(plim_cfg);
	endfunction

	// busy bytes before a response, always fewer than the poll limit
	function automatic int short_wait();
		int w;
		w = eff_limit() - 1;
		if (w > 4) begin
			w = 4;
		end
		return $urandom_range(0, w);
	endfunction

	function automatic void push_busy(input int n);
		repeat (n) push_rx(8'h80 | 8'($urandom_range(0, 127)));
	endfunction

	function automatic bit [7:0] non_token();
		bit [7:0] x;
		do x = 8'($urandom); while (x == tok_cfg);
		return x;
	endfunction

	// start plus the seven bytes that clock out the command frame
	function automatic void push_cmd(input bit [31:0] count);
		push_start($urandom, count);
		repeat (7) push_rx(8'($urandom));
	endfunction

	function automatic void push_reject();
		push_cmd($urandom);
		push_busy(short_wait());
		push_rx(8'($urandom_range(1, 127)));
		repeat (flush_cfg) push_rx(8'($urandom));
	endfunction

	function automatic void push_silent();
		push_cmd($urandom);
		push_busy(eff_limit());
		repeat (flush_cfg) push_rx(8'($urandom));
	endfunction

	// complete read; bad_blk selects a block whose CRC gets one bit flipped (-1: none)
	function automatic void push_read(input bit [31:0] count, input int nblk, input int bad_blk);
		bit [15:0] c;
		bit [7:0]  d;
		push_cmd(count);
		push_busy(short_wait());
		push_rx(8'h00);
		for (int blk = 0; blk < nblk; blk++) begin
			repeat ($urandom_range(0, 4)) push_rx(non_token());
			push_rx(tok_cfg);
			c = '0;
			repeat (BLOCK_BYTES) begin
				d = 8'($urandom);
				c = crc16_next(c, d);
				push_rx(d);
			end
			if (blk == bad_blk) begin
				c ^= 16'd1 << $urandom_range(0, 15);
			end
			push_rx(c[15:8]);
			push_rx(c[7:0]);
			if (blk == bad_blk) begin
				break;
			end
		end
		// stop frame, its poll, then the pad byte that ends the read
		repeat (7) push_rx(8'($urandom));
		if (eff_limit() <= 20 && $urandom_range(0, 1)) begin
			push_busy(eff_limit());
		end else begin
			push_busy(short_wait());
			push_rx(8'($urandom_range(0, 127)));
		end
		push_rx(8'($urandom));
	endfunction

	// well-formed read cut short somewhere; the next start abandons it
	function automatic void push_abort();
		int mark;
		int cut;
		mark = spi_beats.size();
		push_cmd($urandom);
		push_busy(short_wait());
		push_rx(8'h00);
		repeat ($urandom_range(0, 3)) push_rx(non_token());
		push_rx(tok_cfg);
		repeat ($urandom_range(0, 40)) push_rx(8'($urandom));
		cut = $urandom_range(1, spi_beats.size() - mark);
		while (spi_beats.size() > mark + cut)
			void'(spi_beats.pop_back());
	endfunction

	// mixed traffic; always ends with a finished reject so the engine is idle
	function automatic void queue_random_traffic(input int budget);
		int mark;
		mark = spi_beats.size();
		while (spi_beats.size() - mark < budget) begin
			case ($urandom_range(0, 9))
				0, 1, 2: push_reject();
				3, 4: begin
					if (eff_limit() <= 20) begin
						push_silent();
					end else begin
						push_reject();
					end
				end
				5, 6, 7: push_abort();
				8: begin
					push_start($urandom, $urandom);
					repeat ($urandom_range(0, 20)) push_rx(8'($urandom));
				end
				default: repeat ($urandom_range(1, 3)) push_rx(8'($urandom));
			endcase
		end
		push_reject();
	endfunction

	// mostly short idles, a few long ones, and flips into runs with none
	function automatic int pick_gap(inout bit quiet);
		int r;
		if ($urandom_range(0, 49) == 0) begin
			quiet = !quiet;
		end
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic void field_check(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %02h, got %02h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Request driver: the predictor runs at the edge a beat is taken, the
	// next beat (or an idle) goes out on the falling edge after it.
	// ------------------------------------------------------------------
	beat_t cur_beat;
	bit    req_took = 1'b0;
	bit    req_quiet = 1'b0;
	int    req_gap = 0;

	always @(posedge clk) begin
		req_took = 1'b0;
		if (arst_n && req_valid && !req_stall) begin
			req_took = 1'b1;
			results_due.push_back(spi_read_step(cur_beat));
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_took)) begin
			if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (spi_beats.size() > 0) begin
				cur_beat = spi_beats.pop_front();
				req_valid   <= 1'b1;
				req_type    <= cur_beat.kind;
				start_lba   <= cur_beat.lba;
				block_count <= cur_beat.count;
				rx_byte     <= cur_beat.rx;
				req_gap = pick_gap(req_quiet);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: random back-pressure, each taken beat checked against
	// the oldest prediction field by field.
	// ------------------------------------------------------------------
	bit res_quiet = 1'b0;
	int res_hold = 0;

	always @(negedge clk) begin
		if (res_hold > 0) begin
			res_hold--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
			res_hold = pick_gap(res_quiet);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (results_due.size() == 0) begin
				$display("%0t ns: result beat with nothing expected, expected none, got %p",
					$time, {tx_valid, tx_byte, data_valid, data_byte, done_res, status});
				mismatches++;
			end else begin
				want = results_due.pop_front();
				field_check("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
				field_check("tx_byte", want.tx_byte, tx_byte);
				field_check("data_valid", 8'(want.data_valid), 8'(data_valid));
				field_check("data_byte", want.data_byte, data_byte);
				field_check("done_res", 8'(want.done_res), 8'(done_res));
				field_check("status", 8'(want.status), 8'(status));
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any accepted beat on either channel counts as progress
	// ------------------------------------------------------------------
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("%0t ns: watchdog, no beat accepted for %0d cycles, %0d results owed",
					$time, stuck_cycles, results_due.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Configuration and phase sequencing
	// ------------------------------------------------------------------

	// APB write (setup + access), then read back the field
	task automatic reg_write(input logic [1:0] idx, input bit [7:0] val);
		bit [7:0] mask;
		mask = (idx == REG_FLUSH_COUNT) ? 8'h0F : 8'hFF;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		// bits above the field are noise the register must ignore
		pwdata  <= ($urandom & ~{24'h0, mask}) | {24'h0, val & mask};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DATA_TOKEN:  tok_cfg   = val;
			REG_POLL_LIMIT:  plim_cfg  = val;
			default:         flush_cfg = val[3:0];
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		field_check("register readback", val & mask, prdata[7:0] & mask);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// every beat sent, every result back, then a settling wait
	task automatic wait_drained();
		do @(posedge clk); while (spi_beats.size() != 0 || req_valid || results_due.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: token left at reset, poll limit zero and flush zero
		reg_write(REG_POLL_LIMIT, 8'd0);
		reg_write(REG_FLUSH_COUNT, 8'd0);
		// bytes while idle are dropped
		push_rx(8'hFF);
		push_rx(8'h00);
		// all-ones address and count, abandoned mid-frame by a new start
		push_start(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		repeat (3) push_rx(8'h00);
		// random address, count zero; one busy byte exhausts the zero limit
		// and with flush zero the read ends on that byte
		push_cmd(32'd0);
		push_rx(8'h80);
		// immediate reject, again ended on the response byte
		push_cmd($urandom);
		push_rx(8'h01);
		wait_drained();

		// Widest poll window, longest flush; two-block read, CRC fault on either or none
		reg_write(REG_DATA_TOKEN, 8'($urandom));
		reg_write(REG_POLL_LIMIT, 8'd255);
		reg_write(REG_FLUSH_COUNT, 8'd15);
		queue_random_traffic(20);
		push_read(32'd2, 2, int'($urandom_range(0, 2)) - 1);
		queue_random_traffic(20);
		wait_drained();

		// Token zero equals the good R1 response; narrowest poll, single flush byte
		reg_write(REG_DATA_TOKEN, 8'h00);
		reg_write(REG_POLL_LIMIT, 8'd1);
		reg_write(REG_FLUSH_COUNT, 8'd1);
		queue_random_traffic(20);
		push_read($urandom_range(0, 1), 1, $urandom_range(0, 1) ? 0 : -1);
		queue_random_traffic(20);
		wait_drained();

		// Token 0xFF looks like idle bus; short random windows
		reg_write(REG_DATA_TOKEN, 8'hFF);
		reg_write(REG_POLL_LIMIT, 8'($urandom_range(2, 12)));
		reg_write(REG_FLUSH_COUNT, 8'($urandom_range(0, 15)));
		queue_random_traffic(50);
		wait_drained();

		reg_write(REG_DATA_TOKEN, 8'($urandom));
		reg_write(REG_POLL_LIMIT, 8'($urandom_range(1, 20)));
		reg_write(REG_FLUSH_COUNT, 8'($urandom_range(0, 15)));
		queue_random_traffic(50);
		wait_drained();

		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
